/* hdl/tli_pkg.sv */
// Shared types, constants and helpers of the table Lagrange interpolator.
// Used by tli_ctrl, tli_dp and table_lagrange_interpolator; no dependencies.
package tli_pkg;

   localparam int unsigned DEF_MAX_POINTS = 256;

   localparam int DATA_W    = 32;
   localparam int CNT_W     = 9;
   localparam int DEG_W     = 2;
   localparam int STAT_W    = 2;
   localparam int IDX_W     = 8;
   localparam int CSR_IDX_W = 1;
   localparam int STEP_W    = 6;
   localparam int NODE_W    = 2;
   localparam int NODES     = 4;
   localparam int MAG_W     = 33;
   localparam int DVD_W     = 63;
   localparam int WORD_W    = 64;
   localparam int PROD_W    = 128;
   localparam int FRAC_BITS = 30;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLY_DEGREE = 1'b1;

   localparam logic [CNT_W-1:0] RST_POINT_COUNT = 9'd3;
   localparam logic [DEG_W-1:0] RST_POLY_DEGREE = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_ORDER = 2'd2;

   localparam logic [STEP_W-1:0] DIV_LAST = 6'd62;
   localparam logic [STEP_W-1:0] MUL_LAST = 6'd4;

   localparam logic [WORD_W-1:0] WEIGHT_CAP = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam logic [WORD_W-1:0] TERM_CAP   = 64'h1000_0000_0000_0000;
   localparam logic [WORD_W-1:0] WEIGHT_ONE = 64'h0000_0000_4000_0000;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LOAD,
      DP_LOAD_P,
      DP_CAP_X0,
      DP_CAP_XL,
      DP_CHECK,
      DP_SRCH_STEP,
      DP_WINDOW,
      DP_NODE_CAP,
      DP_TERM_INIT,
      DP_FACT_INIT,
      DP_DIV_STEP,
      DP_MUL_W_INIT,
      DP_MUL_T_INIT,
      DP_MUL_STEP,
      DP_W_SAT,
      DP_TERM_ACC,
      DP_RESULT
   } dp_op_type;

   typedef enum logic [2:0] {
      ADDR_REQ,
      ADDR_ZERO,
      ADDR_LAST,
      ADDR_MID,
      ADDR_NODE
   } addr_sel_type;

   typedef struct packed {
      dp_op_type          op;
      addr_sel_type       addr_sel;
      logic [NODE_W-1:0]  node_i;
      logic [NODE_W-1:0]  node_j;
      logic [STEP_W-1:0]  step;
   } dp_cmd_type;

   typedef struct packed {
      logic              order_err;
      logic              out_range;
      logic              srch_done;
      logic              skip;
      logic [NODE_W-1:0] last_node;
   } dp_sts_type;

   function automatic logic [WORD_W-1:0] sat_shift(input logic [PROD_W-1:0] prod,
                                                   input logic [WORD_W-1:0] cap);
      logic [WORD_W-1:0] r;
      r = prod[WORD_W+FRAC_BITS-1:FRAC_BITS];
      if (prod[PROD_W-1:WORD_W+FRAC_BITS] != '0) begin
         return cap;
      end
      if (r > cap) begin
         return cap;
      end
      return r;
   endfunction

endpackage

/* hdl/tli_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module tli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      read_data_ff <= mem_ff[address];
   end

   assign read_data = read_data_ff;

endmodule

/* hdl/tli_ctrl.sv */
// Sequencer of the interpolator: handshakes, search, node fetch and evaluation loops.
// Depends on tli_pkg; drives tli_dp through dp_cmd_type.
module tli_ctrl
   import tli_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_op,
   input  logic       rsp_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd,
   output logic       req_stall,
   output logic       rsp_valid
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAP_X0,
      ST_CAP_XL,
      ST_CHECK,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_WINDOW,
      ST_NODE_RD,
      ST_NODE_CAP,
      ST_TERM_INIT,
      ST_FACT,
      ST_DIV,
      ST_MUL_W,
      ST_W_SAT,
      ST_MUL_T,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              term_ff, term_in;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cnt_in       = cnt_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = DP_NOP;
      cmd.addr_sel = ADDR_NODE;
      cmd.node_i   = i_ff;
      cmd.node_j   = j_ff;
      cmd.step     = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.addr_sel = (req_op == OP_LOAD) ? ADDR_REQ : ADDR_ZERO;
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  cmd.op   = DP_LOAD;
                  state_in = ST_FINISH;
               end else begin
                  cmd.op   = DP_LOAD_P;
                  state_in = ST_CAP_X0;
               end
            end
         end
         ST_CAP_X0: begin
            cmd.op       = DP_CAP_X0;
            cmd.addr_sel = ADDR_LAST;
            state_in     = ST_CAP_XL;
         end
         ST_CAP_XL: begin
            cmd.op   = DP_CAP_XL;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.op   = DP_CHECK;
            state_in = (sts.order_err || sts.out_range) ? ST_FINISH : ST_SRCH_RD;
         end
         ST_SRCH_RD: begin
            cmd.addr_sel = ADDR_MID;
            state_in     = sts.srch_done ? ST_WINDOW : ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            cmd.op   = DP_SRCH_STEP;
            state_in = ST_SRCH_RD;
         end
         ST_WINDOW: begin
            cmd.op   = DP_WINDOW;
            i_in     = '0;
            state_in = ST_NODE_RD;
         end
         ST_NODE_RD: begin
            state_in = ST_NODE_CAP;
         end
         ST_NODE_CAP: begin
            cmd.op = DP_NODE_CAP;
            if (i_ff == sts.last_node) begin
               j_in     = '0;
               state_in = ST_TERM_INIT;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_NODE_RD;
            end
         end
         ST_TERM_INIT: begin
            cmd.op   = DP_TERM_INIT;
            i_in     = '0;
            state_in = ST_FACT;
         end
         ST_FACT: begin
            if (sts.skip) begin
               if (i_ff == sts.last_node) begin
                  cmd.op   = DP_MUL_T_INIT;
                  cnt_in   = '0;
                  term_in  = 1'b1;
                  state_in = ST_MUL_T;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               cmd.op   = DP_FACT_INIT;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op = DP_DIV_STEP;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_MUL_W;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (cnt_ff == DIV_LAST) begin
               term_in = 1'b0;
            end
         end
         ST_MUL_W: begin
            if (!term_ff) begin
               cmd.op  = DP_MUL_W_INIT;
               term_in = 1'b1;
            end else begin
               cmd.op = DP_MUL_STEP;
               if (cnt_ff == MUL_LAST) begin
                  state_in = ST_W_SAT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_W_SAT: begin
            cmd.op = DP_W_SAT;
            if (i_ff == sts.last_node) begin
               state_in = ST_FACT;
               i_in     = i_ff;
               cnt_in   = '0;
               state_in = ST_MUL_T;
               term_in  = 1'b0;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_FACT;
            end
         end
         ST_MUL_T: begin
            if (!term_ff) begin
               cmd.op  = DP_MUL_T_INIT;
               term_in = 1'b1;
            end else if (cnt_ff == MUL_LAST + 1'b1) begin
               cmd.op = DP_TERM_ACC;
               if (j_ff == sts.last_node) begin
                  state_in = ST_FINISH;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_TERM_INIT;
               end
            end else begin
               cmd.op = DP_MUL_STEP;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = DP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         cnt_ff       <= '0;
         term_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         cnt_ff       <= cnt_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/tli_dp.sv */
// Datapath: table RAMs, interval search, node registers, serial divider,
// partial-product multiplier, term accumulator and result register.
// Depends on tli_pkg and tli_ram; commanded by tli_ctrl.
module tli_dp
   import tli_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                     clock,
   input  dp_cmd_type               cmd,
   output dp_sts_type               sts,
   input  logic [CNT_W-1:0]         point_count,
   input  logic [DEG_W-1:0]         poly_degree,
   input  logic [IDX_W-1:0]         req_point_index,
   input  logic signed [DATA_W-1:0] req_x_value,
   input  logic signed [DATA_W-1:0] req_y_value,
   output logic signed [DATA_W-1:0] rsp_interp_value,
   output logic [STAT_W-1:0]        rsp_status
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = ($clog2(MAX_POINTS + 1) > CNT_W) ? $clog2(MAX_POINTS + 1) : CNT_W;

   logic signed [DATA_W-1:0] p_ff, p_in, x0_ff, x0_in, xl_ff, xl_in;
   logic [AW-1:0]            lo_ff, lo_in, hi_ff, hi_in, start_ff, start_in;
   logic signed [DATA_W-1:0] xs_ff [NODES];
   logic signed [DATA_W-1:0] ys_ff [NODES];
   logic signed [DATA_W-1:0] xj_ff, xj_in, yj_ff, yj_in;
   logic [WORD_W-1:0]        w_ff, w_in;
   logic                     neg_ff, neg_in;
   logic [MAG_W-1:0]         rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DVD_W-1:0]         qd_ff, qd_in;
   logic [WORD_W-1:0]        ma_ff, ma_in, mb_ff, mb_in, pp_ff, pp_in;
   logic [1:0]               sh_ff, sh_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [WORD_W-1:0]        acc_ff, acc_in;
   logic [STAT_W-1:0]        stat_ff, stat_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;

   logic [NW-1:0]            count_ext, n_w;
   logic [AW-1:0]            last_a, mid, ram_addr, start_c;
   logic [DEG_W-1:0]         d_w;
   logic                     ram_we;
   logic [DATA_W-1:0]        x_rd, y_rd;
   logic [NODE_W-1:0]        rd_idx;
   logic signed [DATA_W-1:0] xs_rd;
   logic signed [MAG_W-1:0]  num, den;
   logic [MAG_W-1:0]         num_mag, den_mag;
   logic [MAG_W:0]           trial, diff;
   logic                     ge;
   logic [DATA_W-1:0]        a_part, b_part;
   logic [WORD_W-1:0]        term;
   logic [DATA_W-1:0]        y_mag;

   always_comb begin
      count_ext = NW'(point_count);
      if (count_ext < NW'(3)) begin
         n_w = NW'(3);
      end else if (count_ext > NW'(MAX_POINTS)) begin
         n_w = NW'(MAX_POINTS);
      end else begin
         n_w = count_ext;
      end
      last_a = AW'(n_w - NW'(1));
      if (poly_degree == 2'd0) begin
         d_w = 2'd1;
      end else if (poly_degree == 2'd3 && n_w == NW'(3)) begin
         d_w = 2'd2;
      end else begin
         d_w = poly_degree;
      end
   end

   assign mid = AW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);

   always_comb begin
      case (cmd.addr_sel)
         ADDR_REQ:  ram_addr = AW'(req_point_index);
         ADDR_ZERO: ram_addr = '0;
         ADDR_LAST: ram_addr = last_a;
         ADDR_MID:  ram_addr = mid;
         ADDR_NODE: ram_addr = start_ff + AW'(cmd.node_i);
         default:   ram_addr = '0;
      endcase
   end

   assign ram_we = (cmd.op == DP_LOAD) && (32'(req_point_index) < MAX_POINTS);

   tli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_x_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .address      (ram_addr),
      .write_data   (req_x_value),
      .read_data    (x_rd)
   );

   tli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_y_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .address      (ram_addr),
      .write_data   (req_y_value),
      .read_data    (y_rd)
   );

   always_comb begin
      if (lo_ff == '0 || (lo_ff == AW'(1) && d_w == 2'd3)) begin
         start_c = '0;
      end else if (lo_ff == last_a - AW'(1) || (d_w == 2'd3 && lo_ff == last_a - AW'(2))) begin
         start_c = last_a - AW'(d_w);
      end else if (d_w == 2'd1) begin
         start_c = lo_ff;
      end else begin
         start_c = lo_ff - AW'(1);
      end
   end

   assign rd_idx  = (cmd.op == DP_TERM_INIT) ? cmd.node_j : cmd.node_i;
   assign xs_rd   = xs_ff[rd_idx];
   assign num     = {p_ff[DATA_W-1], p_ff} - {xs_rd[DATA_W-1], xs_rd};
   assign den     = {xj_ff[DATA_W-1], xj_ff} - {xs_rd[DATA_W-1], xs_rd};
   assign num_mag = num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
   assign den_mag = den[MAG_W-1] ? MAG_W'(-den) : MAG_W'(den);

   assign trial = {rem_ff, qd_ff[DVD_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   assign a_part = cmd.step[1] ? ma_ff[WORD_W-1:DATA_W] : ma_ff[DATA_W-1:0];
   assign b_part = cmd.step[0] ? mb_ff[WORD_W-1:DATA_W] : mb_ff[DATA_W-1:0];
   assign term   = sat_shift(prod_ff, TERM_CAP);
   assign y_mag  = yj_ff[DATA_W-1] ? DATA_W'(-yj_ff) : DATA_W'(yj_ff);

   assign sts.order_err = (xl_ff <= x0_ff);
   assign sts.out_range = (p_ff < x0_ff) || (p_ff > xl_ff);
   assign sts.srch_done = (hi_ff - lo_ff) <= AW'(1);
   assign sts.skip      = (xs_rd == xj_ff);
   assign sts.last_node = d_w;

   always_comb begin
      p_in          = p_ff;
      x0_in         = x0_ff;
      xl_in         = xl_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      start_in      = start_ff;
      xj_in         = xj_ff;
      yj_in         = yj_ff;
      w_in          = w_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      dsr_in        = dsr_ff;
      qd_in         = qd_ff;
      ma_in         = ma_ff;
      mb_in         = mb_ff;
      pp_in         = pp_ff;
      sh_in         = sh_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      stat_in       = stat_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      case (cmd.op)
         DP_LOAD: begin
            acc_in  = '0;
            stat_in = STATUS_OK;
         end
         DP_LOAD_P: p_in  = req_x_value;
         DP_CAP_X0: x0_in = x_rd;
         DP_CAP_XL: xl_in = x_rd;
         DP_CHECK: begin
            acc_in = '0;
            lo_in  = '0;
            hi_in  = last_a;
            if (sts.order_err) begin
               stat_in = STATUS_ORDER;
            end else if (sts.out_range) begin
               stat_in = STATUS_RANGE;
            end else begin
               stat_in = STATUS_OK;
            end
         end
         DP_SRCH_STEP: begin
            if (p_ff < $signed(x_rd)) begin
               hi_in = mid;
            end else begin
               lo_in = mid;
            end
         end
         DP_WINDOW: start_in = start_c;
         DP_TERM_INIT: begin
            xj_in  = xs_rd;
            yj_in  = ys_ff[cmd.node_j];
            w_in   = WEIGHT_ONE;
            neg_in = 1'b0;
         end
         DP_FACT_INIT: begin
            rem_in = '0;
            dsr_in = den_mag;
            qd_in  = {num_mag, FRAC_BITS'(0)};
            neg_in = neg_ff ^ (num[MAG_W-1] != den[MAG_W-1]);
         end
         DP_DIV_STEP: begin
            rem_in = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            qd_in  = {qd_ff[DVD_W-2:0], ge};
         end
         DP_MUL_W_INIT: begin
            ma_in   = w_ff;
            mb_in   = WORD_W'(qd_ff);
            prod_in = '0;
         end
         DP_MUL_T_INIT: begin
            ma_in   = w_ff;
            mb_in   = WORD_W'(y_mag);
            neg_in  = neg_ff ^ yj_ff[DATA_W-1];
            prod_in = '0;
         end
         DP_MUL_STEP: begin
            pp_in = a_part * b_part;
            sh_in = 2'(cmd.step[1]) + 2'(cmd.step[0]);
            if (cmd.step != '0) begin
               prod_in = prod_ff + (PROD_W'(pp_ff) << (DATA_W * sh_ff));
            end
         end
         DP_W_SAT: w_in = sat_shift(prod_ff, WEIGHT_CAP);
         DP_TERM_ACC: acc_in = neg_ff ? acc_ff - term : acc_ff + term;
         DP_RESULT: begin
            rsp_status_in = stat_ff;
            if ($signed(acc_ff) > 64'sd2147483647) begin
               rsp_value_in = 32'sh7FFF_FFFF;
            end else if ($signed(acc_ff) < -64'sd2147483648) begin
               rsp_value_in = 32'sh8000_0000;
            end else begin
               rsp_value_in = acc_ff[DATA_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      x0_ff         <= x0_in;
      xl_ff         <= xl_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      start_ff      <= start_in;
      xj_ff         <= xj_in;
      yj_ff         <= yj_in;
      w_ff          <= w_in;
      neg_ff        <= neg_in;
      rem_ff        <= rem_in;
      dsr_ff        <= dsr_in;
      qd_ff         <= qd_in;
      ma_ff         <= ma_in;
      mb_ff         <= mb_in;
      pp_ff         <= pp_in;
      sh_ff         <= sh_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      stat_ff       <= stat_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      if (cmd.op == DP_NODE_CAP) begin
         xs_ff[cmd.node_i] <= x_rd;
         ys_ff[cmd.node_i] <= y_rd;
      end
   end

   assign rsp_interp_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

/* hdl/table_lagrange_interpolator.sv */
// Table-driven piecewise Lagrange interpolator, Q16.16 in and out.
// A load beat writes one (x, y) point; its result is (0, status ok). A query beat reads
// x[0] and x[last] and checks order and range; one that fails goes straight to its
// result. Any other query binary-searches the interval, fetches degree+1 nodes, then
// runs the Lagrange sum. Every factor is a bit-serial divide plus a multiply through
// one 32x32 multiplier. Every term adds a multiply and accumulate. The response sits
// in an output register, so the next beat is taken while a result waits.
// Depends on tli_pkg, tli_ctrl, tli_dp and tli_ram.
module table_lagrange_interpolator
   import tli_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op,
   input  logic [IDX_W-1:0]         req_point_index,
   input  logic signed [DATA_W-1:0] req_x_value,
   input  logic signed [DATA_W-1:0] req_y_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_interp_value,
   output logic [STAT_W-1:0]        rsp_status,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CNT_W-1:0]         csr_write_data
);

   logic [CNT_W-1:0] point_count_ff, point_count_in;
   logic [DEG_W-1:0] poly_degree_ff, poly_degree_in;
   dp_cmd_type       cmd;
   dp_sts_type       sts;

   always_comb begin
      point_count_in = point_count_ff;
      poly_degree_in = poly_degree_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_POINT_COUNT: point_count_in = csr_write_data;
            CSR_POLY_DEGREE: poly_degree_in = csr_write_data[DEG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= RST_POINT_COUNT;
         poly_degree_ff <= RST_POLY_DEGREE;
      end else begin
         point_count_ff <= point_count_in;
         poly_degree_ff <= poly_degree_in;
      end
   end

   tli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   tli_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .sts              (sts),
      .point_count      (point_count_ff),
      .poly_degree      (poly_degree_ff),
      .req_point_index  (req_point_index),
      .req_x_value      (req_x_value),
      .req_y_value      (req_y_value),
      .rsp_interp_value (rsp_interp_value),
      .rsp_status       (rsp_status)
   );

endmodule

/* verif/table_lagrange_interpolator_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of table_lagrange_interpolator: loads, queries and
// register settings, checked beat by beat against a scoreboard class.
// Depends on tli_pkg and the table_lagrange_interpolator RTL.
module table_lagrange_interpolator_tb;
   import tli_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam int IDLE_LIMIT  = 30000;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic [STAT_W-1:0]        status;
   } interp_result_type;

   class interp_scoreboard_type;
      logic signed [DATA_W-1:0] x_tab [TABLE_DEPTH];
      logic signed [DATA_W-1:0] y_tab [TABLE_DEPTH];
      int unsigned count_reg;
      int unsigned degree_reg;
      interp_result_type expected_results [$];
      int errors;

      function new();
         count_reg  = RST_POINT_COUNT;
         degree_reg = RST_POLY_DEGREE;
         errors     = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
         if (idx == CSR_POINT_COUNT) count_reg = data;
         else degree_reg = data[DEG_W-1:0];
      endfunction

      function int unsigned points_in_use();
         if (count_reg < 3) return 3;
         if (count_reg > TABLE_DEPTH) return TABLE_DEPTH;
         return count_reg;
      endfunction

      function logic [63:0] mag(longint v);
         return (v < 0) ? -v : v;
      endfunction

      function logic [63:0] mul_frac_sat(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
         logic [127:0] pr;
         logic [63:0]  r;
         pr = {64'd0, a} * {64'd0, b};
         if (pr[127:94] != '0) return cap;
         r = pr[93:30];
         return (r > cap) ? cap : r;
      endfunction

      function interp_result_type lagrange_at(logic signed [DATA_W-1:0] pos);
         interp_result_type res;
         int unsigned n, d, lo, hi, mid, e, len, start;
         longint p, x0, xl, acc;
         longint xs [4];
         longint ys [4];
         logic [63:0] w, f, term;
         longint num, den;
         bit neg;
         res.value  = '0;
         res.status = STATUS_OK;
         n = points_in_use();
         d = (degree_reg < 1) ? 1 : degree_reg;
         if (d > n - 1) d = n - 1;
         x0 = x_tab[0];
         xl = x_tab[n-1];
         p  = pos;
         if (xl <= x0) begin
            res.status = STATUS_ORDER;
            return res;
         end
         if (p < x0 || p > xl) begin
            res.status = STATUS_RANGE;
            return res;
         end
         lo = 0;
         hi = n - 1;
         while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (p < longint'(x_tab[mid])) hi = mid;
            else lo = mid;
         end
         e = lo;
         len = d + 1;
         if (e == 0 || (e == 1 && d == 3)) start = 0;
         else if (e == n - 2 || (d == 3 && e == n - 3)) start = n - len;
         else if (d == 1) start = e;
         else start = e - 1;
         for (int i = 0; i < len; i++) begin
            xs[i] = x_tab[start+i];
            ys[i] = y_tab[start+i];
         end
         acc = 0;
         for (int j = 0; j < len; j++) begin
            neg = 0;
            w = WEIGHT_ONE;
            for (int i = 0; i < len; i++) begin
               if (xs[i] != xs[j]) begin
                  num = p - xs[i];
                  den = xs[j] - xs[i];
                  f = (mag(num) << FRAC_BITS) / mag(den);
                  if ((num < 0) != (den < 0)) neg = !neg;
                  w = mul_frac_sat(w, f, WEIGHT_CAP);
               end
            end
            term = mul_frac_sat(w, mag(ys[j]), TERM_CAP);
            if (ys[j] < 0) neg = !neg;
            acc += neg ? -longint'(term) : longint'(term);
         end
         if (acc > 64'sd2147483647) acc = 64'sd2147483647;
         if (acc < -64'sd2147483648) acc = -64'sd2147483648;
         res.value = acc[31:0];
         return res;
      endfunction

      function void note_request(logic op, logic [IDX_W-1:0] idx,
                                 logic signed [DATA_W-1:0] xv,
                                 logic signed [DATA_W-1:0] yv);
         interp_result_type res;
         if (op == OP_LOAD) begin
            x_tab[idx] = xv;
            y_tab[idx] = yv;
            res.value  = '0;
            res.status = STATUS_OK;
         end else begin
            res = lagrange_at(xv);
         end
         expected_results.push_back(res);
      endfunction

      function void check_result(logic signed [DATA_W-1:0] value, logic [STAT_W-1:0] status);
         interp_result_type exp_res;
         if (expected_results.size() == 0) begin
            $error("unexpected result beat: interp_value %0d status %0d", value, status);
            errors++;
            return;
         end
         exp_res = expected_results.pop_front();
         if (value !== exp_res.value) begin
            $error("interp_value: expected %0d, actual %0d", exp_res.value, value);
            errors++;
         end
         if (status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_op;
   logic [IDX_W-1:0]         req_point_index;
   logic signed [DATA_W-1:0] req_x_value;
   logic signed [DATA_W-1:0] req_y_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_interp_value;
   logic [STAT_W-1:0]        rsp_status;
   logic                     csr_write_enable;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CNT_W-1:0]         csr_write_data;

   interp_scoreboard_type sb;
   bit hold_request;
   int idle_cycles;

   table_lagrange_interpolator u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_point_index (req_point_index),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_interp_value(rsp_interp_value),
      .rsp_status      (rsp_status),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_op, req_point_index, req_x_value, req_y_value);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_interp_value, rsp_status);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // receiver: short random stalls, rare long ones, one forced long hold
   initial begin
      int r;
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (400) @(negedge clock);
            hold_request = 0;
            rsp_stall = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 15) n = $urandom_range(1, 3);
            else if (r == 99) n = $urandom_range(30, 100);
            else n = 0;
            if (n > 0) begin
               rsp_stall = 1'b1;
               repeat (n) @(negedge clock);
               rsp_stall = 1'b0;
            end
         end
      end
   end

   task automatic send_beat(logic op, logic [IDX_W-1:0] idx,
                            logic signed [DATA_W-1:0] xv, logic signed [DATA_W-1:0] yv);
      int r;
      req_valid       = 1'b1;
      req_op          = op;
      req_point_index = idx;
      req_x_value     = xv;
      req_y_value     = yv;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      r = $urandom_range(0, 99);
      if (r >= 70) begin
         req_valid = 1'b0;
         if (r < 96) repeat ($urandom_range(1, 3)) @(negedge clock);
         else repeat ($urandom_range(20, 80)) @(negedge clock);
      end
   endtask

   task automatic wait_drain();
      req_valid = 1'b0;
      while (sb.expected_results.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
      wait_drain();
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(posedge clock);
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_y();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
   endfunction

   // mostly ascending nodes with some repeats and small reversals
   task automatic fill_table(int unsigned n);
      longint cur, max_step;
      int r;
      cur = -longint'($urandom_range(0, 1 << 30));
      if ($urandom_range(0, 3) == 0) cur = -64'sd2147483648;
      for (int i = 0; i < n; i++) begin
         send_beat(OP_LOAD, IDX_W'(i), cur[31:0], pick_y());
         max_step = (64'sd2147483647 - cur) / (n - i);
         if (max_step < 1) max_step = 1;
         if ($urandom_range(0, 3) == 0 && max_step > 4096) max_step = 4096;
         r = $urandom_range(0, 31);
         if (r == 0) cur = cur;
         else if (r == 1 && i > 0 && i < n - 2) cur = cur - $urandom_range(1, 1000);
         else cur = cur + longint'($urandom_range(1, int'(max_step > 2147483647 ?
                                  2147483647 : max_step)));
         if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      end
   endtask

   task automatic run_mix(int items);
      int unsigned n;
      longint x0, xl, span;
      logic [63:0] rnd;
      logic signed [DATA_W-1:0] pos;
      int r;
      n = sb.points_in_use();
      for (int k = 0; k < items; k++) begin
         r = $urandom_range(0, 99);
         x0 = sb.x_tab[0];
         xl = sb.x_tab[n-1];
         if (r < 10) begin
            send_beat(OP_LOAD, IDX_W'($urandom_range(0, 255)), $urandom, $urandom);
         end else begin
            if (r < 75 && xl >= x0) begin
               span = xl - x0 + 1;
               rnd = {$urandom, $urandom};
               pos = DATA_W'(x0 + longint'(rnd % span));
            end else if (r < 90) begin
               pos = sb.x_tab[$urandom_range(0, n - 1)];
            end else begin
               pos = $urandom;
            end
            send_beat(OP_QUERY, IDX_W'($urandom), pos, $urandom);
         end
      end
   endtask

   initial begin
      int counts [6]  = '{256, 8, 0, 3, 40, 511};
      int degrees [6] = '{3, 1, 0, 3, 2, 2};
      int mixes [6]   = '{200, 250, 150, 150, 250, 150};
      sb = new();
      hold_request     = 0;
      idle_cycles      = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = OP_LOAD;
      req_point_index  = '0;
      req_x_value      = '0;
      req_y_value      = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_POINT_COUNT;
      csr_write_data   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: three points, quadratic
      send_beat(OP_LOAD, 8'd0, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_beat(OP_LOAD, 8'd1, 32'sh0000_0000, 32'sh8000_0000);
      send_beat(OP_LOAD, 8'd2, 32'sh7FFF_FFFF, 32'sh1234_5678);
      send_beat(OP_QUERY, 8'd0, 32'sh8000_0000, '0);
      send_beat(OP_QUERY, 8'd0, 32'sh0000_0000, '0);
      send_beat(OP_QUERY, 8'd0, 32'sh7FFF_FFFF, '0);
      send_beat(OP_QUERY, 8'hFF, 32'sh0000_3039, 32'shFFFF_FFFF);
      send_beat(OP_QUERY, 8'd0, 32'shC000_0001, '0);
      send_beat(OP_LOAD, 8'd2, 32'sh8000_0000, 32'sh0001_0000);
      send_beat(OP_QUERY, 8'd0, 32'sh0000_0000, '0);
      send_beat(OP_LOAD, 8'd2, 32'sh0001_86A0, 32'shFFFF_0000);
      send_beat(OP_QUERY, 8'd0, 32'sh0001_86A1, '0);
      send_beat(OP_QUERY, 8'd0, 32'sh8000_0000, '0);
      send_beat(OP_QUERY, 8'd0, 32'sh8000_0001, '0);
      send_beat(OP_LOAD, 8'hFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
      send_beat(OP_LOAD, 8'd1, 32'sh8000_0000, 32'sh0003_0000);
      send_beat(OP_QUERY, 8'd0, 32'sh0000_0010, '0);
      send_beat(OP_LOAD, 8'd0, 32'sh0000_0000, 32'sh7FFF_FFFF);
      send_beat(OP_LOAD, 8'd1, 32'sh0000_0001, 32'sh8000_0000);
      send_beat(OP_QUERY, 8'd0, 32'sh0000_8000, '0);

      // pause the sender until every result is back
      wait_drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_POINT_COUNT, CNT_W'(counts[ph]));
         write_reg(CSR_POLY_DEGREE, CNT_W'(degrees[ph]));
         if (ph == 1) hold_request = 1;
         fill_table(sb.points_in_use());
         run_mix(mixes[ph]);
      end

      wait_drain();
      repeat (50) @(negedge clock);
      if (sb.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
